// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define LED_ASSERT_ALWAYS(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (expr)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define LED_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/led_pkg.sv -----
// Shared types and constants of the edit distance engine.
package led_pkg;

  // Default string capacity in bytes.
  localparam int LED_MAX_LEN = 64;

  // Field widths of the transfer ports.
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int DIST_W = 7;

  // Input operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_FIRST  = 2'd0,
    FUNC_LOAD_SECOND = 2'd1,
    FUNC_COMPUTE     = 2'd2
  } func_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic start;
    logic row;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic last_cell;
    logic last_row;
    logic out_busy;
  } status_t;

endpackage

// ----- rtl/led_ctrl.sv -----
// Controller state machine: accepts items and sequences the row and cell sweep.
module led_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [led_pkg::FUNC_W-1:0]     in_func,
  output logic                           in_stall,
  input  led_pkg::status_t               status,
  output led_pkg::cmd_t                  cmd
);
  import led_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   in_xfer;

  assign in_xfer = in_valid && (state_r == ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_func == FUNC_COMPUTE)) begin
          state_nxt = status.empty ? ST_DONE : ST_ROW;
        end
      end
      ST_ROW: begin
        state_nxt = ST_CELL;
      end
      ST_CELL: begin
        if (status.last_cell) begin
          state_nxt = status.last_row ? ST_DONE : ST_ROW;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall        = 1'b0;
        cmd.load_first  = in_xfer && (in_func == FUNC_LOAD_FIRST);
        cmd.load_second = in_xfer && (in_func == FUNC_LOAD_SECOND);
        cmd.start       = in_xfer && (in_func == FUNC_COMPUTE);
      end
      ST_ROW: begin
        cmd.row = 1'b1;
      end
      ST_CELL: begin
        cmd.step = 1'b1;
      end
      ST_DONE: begin
        cmd.finish = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/led_dpath.sv -----
// Datapath: string stores, DP row memory, cell arithmetic and result register.
module led_dpath #(
  parameter int MAX_LEN = led_pkg::LED_MAX_LEN
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [led_pkg::CHAR_W-1:0]     in_char_byte,
  input  led_pkg::cmd_t                  cmd,
  output led_pkg::status_t               status,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [led_pkg::DIST_W-1:0]     out_distance,
  output logic                           out_overflow
);
  import led_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  // Storage
  logic [CHAR_W-1:0] first_mem  [MAX_LEN];
  logic [CHAR_W-1:0] second_mem [MAX_LEN];
  logic [LW-1:0]     row_mem    [MAX_LEN];

  logic [LW-1:0]     len1_r, len2_r;
  logic              ovf_r;
  logic [AW-1:0]     i_r, j_r;
  logic [LW-1:0]     left_r, diag_r;
  logic [CHAR_W-1:0] fa_rd_r, sb_rd_r;
  logic [LW-1:0]     row_rd_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_distance_r;
  logic              out_overflow_r;

  logic          full1, full2;
  logic [AW-1:0] rd_addr;
  logic [LW:0]   up, up_inc, left_inc, sub, min_a, cur_w;
  logic [LW-1:0] cur;
  logic          row0;

  assign full1 = (len1_r == LW'(MAX_LEN));
  assign full2 = (len2_r == LW'(MAX_LEN));

  // Status toward the controller
  assign status.empty     = (len1_r == '0) || (len2_r == '0);
  assign status.last_cell = ((LW'(j_r) + LW'(1)) == len2_r);
  assign status.last_row  = ((LW'(i_r) + LW'(1)) == len1_r);
  assign status.out_busy  = out_valid_r && out_stall;

  // String loads
  always_ff @(posedge clk) begin
    if (cmd.load_first && !full1) begin
      first_mem[len1_r[AW-1:0]] <= in_char_byte;
    end
    if (cmd.load_second && !full2) begin
      second_mem[len2_r[AW-1:0]] <= in_char_byte;
    end
  end

  // Lengths and sticky drop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len1_r <= '0;
      len2_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.finish) begin
      len1_r <= '0;
      len2_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (cmd.load_first) begin
        if (full1) ovf_r <= 1'b1;
        else       len1_r <= len1_r + LW'(1);
      end
      if (cmd.load_second) begin
        if (full2) ovf_r <= 1'b1;
        else       len2_r <= len2_r + LW'(1);
      end
    end
  end

  // Read side: row start reads entry 0, a cell prefetches the next entry
  assign rd_addr = cmd.step ? (j_r + AW'(1)) : '0;

  always_ff @(posedge clk) begin
    if (cmd.row) begin
      fa_rd_r <= first_mem[i_r];
    end
    if (cmd.row || cmd.step) begin
      sb_rd_r  <= second_mem[rd_addr];
      row_rd_r <= row_mem[rd_addr];
    end
  end

  // Cell arithmetic: min of up+1, left+1, diag+mismatch
  assign row0     = (i_r == '0);
  assign up       = row0 ? ((LW+1)'(j_r) + (LW+1)'(1)) : {1'b0, row_rd_r};
  assign up_inc   = up + (LW+1)'(1);
  assign left_inc = {1'b0, left_r} + (LW+1)'(1);
  assign sub      = {1'b0, diag_r} + (LW+1)'(fa_rd_r != sb_rd_r);
  assign min_a    = (up_inc < left_inc) ? up_inc : left_inc;
  assign cur_w    = (min_a < sub) ? min_a : sub;
  assign cur      = cur_w[LW-1:0];

  // Row memory write-back
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      row_mem[j_r] <= cur;
    end
  end

  // Sweep counters and neighbor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.start) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.step) begin
      if (status.last_cell) begin
        j_r <= '0;
        i_r <= i_r + AW'(1);
      end else begin
        j_r <= j_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      // one string empty: the distance is the other length
      left_r <= len1_r + len2_r;
    end else if (cmd.row) begin
      left_r <= LW'(i_r) + LW'(1);
      diag_r <= LW'(i_r);
    end else if (cmd.step) begin
      left_r <= cur;
      diag_r <= up[LW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_distance_r <= DIST_W'(left_r);
      out_overflow_r <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_overflow = out_overflow_r;

endmodule

// ----- rtl/levenshtein_edit_distance.sv -----
// Top level of the edit distance engine: controller, datapath and checks.
//
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, in_func, in_char_byte | to block
//  result  | out_valid, out_stall, out_distance,       | from block
//          | out_overflow                             |
//
// Loads are taken back to back. A compute item holds in_stall high through
// a ROW state and a CELL state per byte of the second string for each byte
// of the first string, then DONE; only DONE when a string is empty.
// Reset (rst_n low, synchronous) empties both strings; stores are not cleared.
// A stalled result holds the next compute in its last cycle until out_stall
// drops; items behind that compute wait too.
module levenshtein_edit_distance #(
  parameter int MAX_LEN = led_pkg::LED_MAX_LEN
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [led_pkg::FUNC_W-1:0]     in_func,
  input  logic [led_pkg::CHAR_W-1:0]     in_char_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [led_pkg::DIST_W-1:0]     out_distance,
  output logic                           out_overflow
);
  import led_pkg::*;

  `include "assert_macros.svh"

  cmd_t    cmd;
  status_t status;

  led_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  led_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_char_byte (in_char_byte),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_distance (out_distance),
    .out_overflow (out_overflow)
  );

  // Checks
  `LED_ASSERT_ALWAYS(a_cmd_onehot, clk, rst_n, $onehot0(cmd))
  `LED_ASSERT_NEXT(a_start_stalls, clk, rst_n, cmd.start, in_stall)
  `LED_ASSERT_NEXT(a_row_then_cell, clk, rst_n, cmd.row, cmd.step)
  `LED_ASSERT_NEXT(a_finish_result, clk, rst_n, cmd.finish, out_valid)

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the Levenshtein edit distance engine.
module tb_top;
  import led_pkg::*;

  localparam int MAX_LEN = LED_MAX_LEN;
  // func code the block takes and ignores
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 64;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] data;
  } cmd_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } edit_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [CHAR_W-1:0] in_char_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DIST_W-1:0] out_distance;
  logic              out_overflow;

  // pending commands and predicted results
  cmd_t         cmd_q[$];
  edit_result_t dist_q[$];
  cmd_t         cur_cmd;
  int           n_cmds = 0;
  int           err_count = 0;

  // predictor copy of the string stores
  logic [CHAR_W-1:0] str_a[MAX_LEN];
  logic [CHAR_W-1:0] str_b[MAX_LEN];
  int                len_a = 0;
  int                len_b = 0;
  logic              drop_seen = 1'b0;

  // idle pattern state
  int send_gap = 0;
  int send_calm = 0;
  int recv_gap = 0;
  int recv_calm = 0;
  int results_seen = 0;
  int hold_left = 0;
  logic hold_armed = 1'b1;

  levenshtein_edit_distance #(
    .MAX_LEN(MAX_LEN)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_char_byte(in_char_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_distance(out_distance),
    .out_overflow(out_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Two-column DP over the predicted stores.
  function automatic logic [DIST_W-1:0] edit_distance();
    int prev_col[MAX_LEN+1];
    int cur_col[MAX_LEN+1];
    int sub;
    int best;
    for (int j = 0; j <= len_b; j++) prev_col[j] = j;
    for (int i = 0; i < len_a; i++) begin
      cur_col[0] = i + 1;
      for (int j = 0; j < len_b; j++) begin
        sub = prev_col[j] + ((str_a[i] == str_b[j]) ? 0 : 1);
        best = prev_col[j+1] + 1;
        if (cur_col[j] + 1 < best) best = cur_col[j] + 1;
        if (sub < best) best = sub;
        cur_col[j+1] = best;
      end
      prev_col = cur_col;
    end
    return DIST_W'(prev_col[len_b]);
  endfunction

  // Update the predicted state for one accepted command.
  task automatic step_strings(input cmd_t c);
    edit_result_t res;
    case (c.func)
      FUNC_LOAD_FIRST: begin
        if (len_a < MAX_LEN) begin
          str_a[len_a] = c.data;
          len_a++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      FUNC_LOAD_SECOND: begin
        if (len_b < MAX_LEN) begin
          str_b[len_b] = c.data;
          len_b++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      FUNC_COMPUTE: begin
        res.distance = edit_distance();
        res.overflow = drop_seen;
        dist_q = {dist_q, res};
        len_a = 0;
        len_b = 0;
        drop_seen = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic push_cmd(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] b);
    cmd_t c;
    c.func = f;
    c.data = b;
    cmd_q = {cmd_q, c};
    if (f != FUNC_UNUSED) n_cmds++;
  endtask

  // Narrow alphabet gives plenty of matching bytes.
  function automatic logic [CHAR_W-1:0] rand_byte(input bit narrow);
    if (!narrow) return CHAR_W'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h5A;
      default: return 8'hA5;
    endcase
  endfunction

  // One string pair with interleaved loads, stray unused codes, then compute.
  // In near mode the second string is an edited copy of the first.
  task automatic queue_pair(input int n_a, input int n_b, input bit narrow, input bit near);
    logic [CHAR_W-1:0] a_q[$];
    logic [CHAR_W-1:0] b_q[$];
    int r;
    for (int i = 0; i < n_a; i++) a_q = {a_q, rand_byte(narrow)};
    if (near) begin
      foreach (a_q[i]) begin
        r = $urandom_range(0, 9);
        if (r < 7) b_q = {b_q, a_q[i]};
        else if (r == 7) b_q = {b_q, rand_byte(narrow)};
        else if (r == 8) begin
          b_q = {b_q, a_q[i]};
          b_q = {b_q, rand_byte(narrow)};
        end
      end
    end else begin
      for (int i = 0; i < n_b; i++) b_q = {b_q, rand_byte(narrow)};
    end
    while (a_q.size() > 0 || b_q.size() > 0) begin
      if ($urandom_range(0, 19) == 0)
        push_cmd(FUNC_UNUSED, rand_byte(0));
      if (b_q.size() == 0 || (a_q.size() > 0 && $urandom_range(0, 1) == 0))
        push_cmd(FUNC_LOAD_FIRST, a_q.pop_front());
      else
        push_cmd(FUNC_LOAD_SECOND, b_q.pop_front());
    end
    push_cmd(FUNC_COMPUTE, rand_byte(0));
  endtask

  // Driver: offers queued commands, holds them while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) step_strings(cur_cmd);
      if (send_calm > 0) send_calm--;
      else if ($urandom_range(0, 299) == 0) send_calm = $urandom_range(100, 300);
      if (in_valid && in_stall) begin
        // payload stays put
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cur_cmd = cmd_q.pop_front();
        in_valid <= 1'b1;
        in_func <= cur_cmd.func;
        in_char_byte <= cur_cmd.data;
        send_gap = (send_calm > 0) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer and drives out_stall.
  always @(posedge clk) begin
    edit_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (dist_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: distance %0d overflow %0b",
                                    out_distance, out_overflow));
        end else begin
          want = dist_q.pop_front();
          if (out_distance !== want.distance)
            report_mismatch($sformatf("distance %0d, want %0d", out_distance, want.distance));
          if (out_overflow !== want.overflow)
            report_mismatch($sformatf("overflow %0b, want %0b", out_overflow, want.overflow));
        end
        results_seen <= results_seen + 1;
      end
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 299) == 0) recv_calm = $urandom_range(100, 300);
      if (recv_gap > 0) recv_gap--;
      else if (recv_calm == 0 && $urandom_range(0, 3) == 0) recv_gap = pick_gap();
      out_stall <= (hold_left > 0) || (recv_gap > 0);
    end
  end

  // Long receiver hold-off once, early on, so the engine backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && results_seen == 3) begin
      hold_left <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    int kind;
    // both strings empty
    push_cmd(FUNC_COMPUTE, 8'hFF);
    // second string empty, extreme bytes
    push_cmd(FUNC_LOAD_FIRST, 8'h00);
    push_cmd(FUNC_LOAD_FIRST, 8'hFF);
    push_cmd(FUNC_COMPUTE, 8'h00);
    // first string empty
    push_cmd(FUNC_LOAD_SECOND, 8'hFF);
    push_cmd(FUNC_LOAD_SECOND, 8'h00);
    push_cmd(FUNC_LOAD_SECOND, 8'h7F);
    push_cmd(FUNC_COMPUTE, 8'h55);
    // unused code changes nothing
    push_cmd(FUNC_UNUSED, 8'hAA);
    push_cmd(FUNC_COMPUTE, 8'h00);
    // one deletion apart
    push_cmd(FUNC_LOAD_FIRST, 8'h00);
    push_cmd(FUNC_LOAD_FIRST, 8'hFF);
    push_cmd(FUNC_LOAD_SECOND, 8'hFF);
    push_cmd(FUNC_LOAD_FIRST, 8'h55);
    push_cmd(FUNC_LOAD_SECOND, 8'h55);
    push_cmd(FUNC_COMPUTE, 8'h00);
    // equal strings with an unused code in between
    push_cmd(FUNC_LOAD_FIRST, 8'hA5);
    push_cmd(FUNC_UNUSED, 8'h55);
    push_cmd(FUNC_LOAD_SECOND, 8'hA5);
    push_cmd(FUNC_COMPUTE, 8'hFF);

    // full strings: both past capacity, then exactly at capacity
    queue_pair(66, 65, 1'b1, 1'b0);
    queue_pair(MAX_LEN, MAX_LEN, 1'b0, 1'b0);
    queue_pair(MAX_LEN, 0, 1'b1, 1'b1);
    while (n_cmds < 1000) begin
      kind = $urandom_range(0, 19);
      if (kind == 0)
        queue_pair($urandom_range(56, 72), $urandom_range(56, 72),
                   $urandom_range(0, 1), $urandom_range(0, 1));
      else if (kind == 1)
        queue_pair($urandom_range(0, 1) * $urandom_range(0, 10),
                   $urandom_range(0, 1) * $urandom_range(0, 10), $urandom_range(0, 1), 1'b0);
      else
        queue_pair($urandom_range(0, 12), $urandom_range(0, 12),
                   $urandom_range(0, 1), $urandom_range(0, 2) == 0);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (cmd_q.size() > 0 || in_valid || dist_q.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
